### rtl/opwf_pkg.sv
// Shared constants for the oil-paint window filter.
`default_nettype none
package opwf_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int BIN_COUNT  = 256;
    localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int BIN_W      = $clog2(BIN_COUNT);
    localparam int CNT_W      = 8;
    localparam int CH_W       = 16;
    localparam int SUM_W      = 3 * CH_W;
    localparam int K_W        = 23;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int RADIUS_W   = 3;
    localparam int X_W        = 10;
    localparam int Y_W        = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH   = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT  = 13'd768;
    localparam logic [RADIUS_W-1:0] RST_WINDOW_RADIUS = 3'd2;
endpackage
`default_nettype wire

### rtl/opwf_if.sv
// Handshake channel interfaces for the oil-paint window filter.
`default_nettype none
interface opwf_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] intensity_bin;
    modport source (output valid, req_type, in_red, in_green, in_blue, intensity_bin,
                    input ready);
    modport sink (input valid, req_type, in_red, in_green, in_blue, intensity_bin,
                  output ready);
endinterface

interface opwf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;
    modport source (output valid, out_red, out_green, out_blue, frame_done, input ready);
    modport sink (input valid, out_red, out_green, out_blue, frame_done, output ready);
endinterface

interface opwf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [opwf_pkg::CFG_IDX_W-1:0]  index;
    logic [opwf_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/oil_paint_window_filter_core.sv
// Oil-paint window filter: line store, window histogram, mode pick and rounded mean.
// Steps per result item: setup, a window walk at one line read per cycle over the window
//   clipped at the frame edges (up to 225 pixels), pipeline drain, histogram scan, three
//   divide-and-round steps (one per channel), emit; emit waits while a result is not taken.
// Items that yield no result leave the block idle; one item is in work at a time.
// Reset: asynchronous, active low; afterwards a pass over every bin clears the histogram
//   memory with input held off. The line store is not cleared.
`default_nettype none
module oil_paint_window_filter_core (
    input  wire            clk,
    input  wire            rst_n,
    opwf_in_if.sink        pix_in,
    opwf_out_if.source     pix_out,
    opwf_cfg_if.sink       cfg
);
    localparam int AW = opwf_pkg::ADDR_W;
    localparam int BW = opwf_pkg::BIN_W;
    localparam int CW = opwf_pkg::CNT_W;
    localparam int SW = opwf_pkg::SUM_W;
    localparam int HW = opwf_pkg::CH_W;
    localparam int KW = opwf_pkg::K_W;
    localparam int XW = opwf_pkg::X_W;
    localparam int YW = opwf_pkg::Y_W;
    localparam int WW = opwf_pkg::WIDTH_W;
    localparam int HTW = opwf_pkg::HEIGHT_W;
    localparam int RW = opwf_pkg::RADIUS_W;
    localparam int SCW = BW + 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SETUP, ST_WALK, ST_DRAIN, ST_SCAN, ST_DIV, ST_ROUND, ST_EMIT
    } state_t;

    // Add two store addresses modulo the store depth.
    function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(opwf_pkg::LINE_DEPTH))
            s = s - (AW+1)'(opwf_pkg::LINE_DEPTH);
        return s[AW-1:0];
    endfunction

    state_t state_reg;

    // Configuration registers and the effective frame geometry.
    logic [WW-1:0]  width_reg;
    logic [HTW-1:0] height_reg;
    logic [RW-1:0]  radius_reg;
    logic [WW-1:0]  w_eff;
    logic [HTW-1:0] h_eff;
    logic [KW-1:0]  total;
    logic [KW-1:0]  delay;
    logic [WW+HTW-1:0] total_full;
    logic [RW+WW-1:0]  rw_prod;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_reg > WW'(opwf_pkg::MAX_WIDTH))
            w_eff = WW'(opwf_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = HTW'(1);
        else if (height_reg > HTW'(opwf_pkg::MAX_HEIGHT))
            h_eff = HTW'(opwf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
        total_full = (WW+HTW)'(w_eff) * (WW+HTW)'(h_eff);
        total      = total_full[KW-1:0];
        rw_prod    = (RW+WW)'(radius_reg) * (RW+WW)'(w_eff);
        delay      = KW'(rw_prod) + KW'(radius_reg);
    end

    // Frame position: item count, store write pointer, centre pixel.
    logic [KW-1:0] k_reg;
    logic [AW-1:0] wa_reg;
    logic [XW-1:0] xc_reg;
    logic [YW-1:0] yc_reg;
    logic [AW-1:0] pa_reg;
    logic          last_reg;

    logic in_acc;
    logic in_pixel;
    logic [KW-1:0] p_idx;
    assign in_acc   = pix_in.valid && pix_in.ready;
    assign in_pixel = (k_reg < total) && !pix_in.req_type;
    assign p_idx    = k_reg - delay;
    assign pix_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    // Window bounds around the centre, clipped at the frame edges.
    logic [YW-1:0] y_lo, y_hi, h_m1;
    logic [YW:0]   y_hi_raw;
    logic [XW-1:0] x_lo, x_hi, w_m1;
    logic [XW:0]   x_hi_raw;
    logic [RW-1:0] dyo, dxo;
    logic [AW-1:0] win_off;
    logic [RW+WW-1:0] dy_prod;
    logic [AW-1:0] win_start;
    logic [YW-1:0] rows_diff;
    logic [XW-1:0] cols_diff;

    always_comb
    begin
        h_m1     = YW'(h_eff - HTW'(1));
        w_m1     = XW'(w_eff - WW'(1));
        y_lo     = (yc_reg >= YW'(radius_reg)) ? yc_reg - YW'(radius_reg) : '0;
        y_hi_raw = {1'b0, yc_reg} + (YW+1)'(radius_reg);
        y_hi     = (y_hi_raw > {1'b0, h_m1}) ? h_m1 : y_hi_raw[YW-1:0];
        x_lo     = (xc_reg >= XW'(radius_reg)) ? xc_reg - XW'(radius_reg) : '0;
        x_hi_raw = {1'b0, xc_reg} + (XW+1)'(radius_reg);
        x_hi     = (x_hi_raw > {1'b0, w_m1}) ? w_m1 : x_hi_raw[XW-1:0];
        rows_diff = y_hi - y_lo;
        cols_diff = x_hi - x_lo;
        dyo      = RW'(yc_reg - y_lo);
        dxo      = RW'(xc_reg - x_lo);
        dy_prod  = (RW+WW)'(dyo) * (RW+WW)'(w_eff);
        win_off  = AW'(dy_prod) + AW'(dxo);
        if (pa_reg >= win_off)
            win_start = pa_reg - win_off;
        else
            win_start = AW'((AW+1)'(pa_reg) + (AW+1)'(opwf_pkg::LINE_DEPTH)
                            - (AW+1)'(win_off));
    end

    // Window walk.
    logic [AW-1:0] rs_reg, a_reg;
    logic [3:0]    col_reg, row_reg, cols_m1_reg, rows_m1_reg;

    // Histogram pipeline.
    logic           s2_vld_reg, s3_vld_reg;
    logic [BW-1:0]  s3_bin_reg;
    logic [SW-1:0]  s3_rgb_reg;
    logic           wr_vld_reg;
    logic [BW-1:0]  wr_bin_reg;
    logic [CW-1:0]  wr_cnt_reg;
    logic [SW-1:0]  wr_sum_reg;
    logic [31:0]    line_q_reg;
    logic [CW-1:0]  cnt_q_reg;
    logic [SW-1:0]  sum_q_reg;
    logic [CW-1:0]  cur_cnt;
    logic [SW-1:0]  cur_sum;

    // Scan and divide.
    logic [SCW-1:0] scan_idx_reg;
    logic           sc_vld_reg;
    logic [BW-1:0]  sc_bin_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic [SW-1:0]  best_sum_reg;
    logic [1:0]     ch_reg;
    logic [3:0]     bit_reg;
    logic [CW:0]    rem_reg;
    logic [HW-1:0]  quo_reg;
    logic [HW-1:0]  div_dvd;
    logic [CW+1:0]  div_sh;
    logic           div_ge;
    logic [CW+1:0]  rem2;
    logic           rnd_up;
    logic [HW:0]    q_rnd;
    logic [7:0]     q_sat;
    logic [7:0]     res_r_reg, res_g_reg, res_b_reg;

    // Output register.
    logic       out_vld_reg;
    logic [7:0] out_r_reg, out_g_reg, out_b_reg;
    logic       out_done_reg;

    assign pix_out.valid      = out_vld_reg;
    assign pix_out.out_red    = out_r_reg;
    assign pix_out.out_green  = out_g_reg;
    assign pix_out.out_blue   = out_b_reg;
    assign pix_out.frame_done = out_done_reg;

    // Forward the previous write when the same bin comes back to back.
    always_comb
    begin
        if (wr_vld_reg && (wr_bin_reg == s3_bin_reg))
        begin
            cur_cnt = wr_cnt_reg;
            cur_sum = wr_sum_reg;
        end
        else
        begin
            cur_cnt = cnt_q_reg;
            cur_sum = sum_q_reg;
        end
    end

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    div_dvd = best_sum_reg[HW-1:0];
            2'd1:    div_dvd = best_sum_reg[2*HW-1:HW];
            default: div_dvd = best_sum_reg[3*HW-1:2*HW];
        endcase
        div_sh = {rem_reg, div_dvd[bit_reg]};
        div_ge = (div_sh >= (CW+2)'(best_cnt_reg));
        rem2   = {rem_reg, 1'b0};
        rnd_up = (rem2 > (CW+2)'(best_cnt_reg))
                 || ((rem2 == (CW+2)'(best_cnt_reg)) && quo_reg[0]);
        q_rnd  = {1'b0, quo_reg} + (HW+1)'(rnd_up);
        if (best_cnt_reg == '0)
            q_sat = '0;
        else if (q_rnd > (HW+1)'(255))
            q_sat = 8'd255;
        else
            q_sat = q_rnd[7:0];
    end

    // Memory port control.
    logic          line_we;
    logic          hist_re, hist_we;
    logic [BW-1:0] hist_ra, hist_wa;
    logic [CW-1:0] hist_wcnt;
    logic [SW-1:0] hist_wsum;

    assign line_we = in_acc && in_pixel;

    always_comb
    begin
        hist_re = s2_vld_reg || ((state_reg == ST_SCAN) && !scan_idx_reg[BW]);
        hist_ra = (state_reg == ST_SCAN) ? scan_idx_reg[BW-1:0] : line_q_reg[31:24];
        hist_we   = 1'b0;
        hist_wa   = scan_idx_reg[BW-1:0];
        hist_wcnt = '0;
        hist_wsum = '0;
        priority if (state_reg == ST_CLEAR)
        begin
            hist_we = 1'b1;
        end
        else if (s3_vld_reg)
        begin
            hist_we   = 1'b1;
            hist_wa   = s3_bin_reg;
            hist_wcnt = cur_cnt + CW'(1);
            hist_wsum = cur_sum + s3_rgb_reg;
        end
        else if (sc_vld_reg)
        begin
            hist_we = 1'b1;
            hist_wa = sc_bin_reg;
        end
    end

    // Line store and histogram memories.
    logic [31:0]   line_mem [opwf_pkg::LINE_DEPTH];
    logic [CW-1:0] cnt_mem  [opwf_pkg::BIN_COUNT];
    logic [SW-1:0] sum_mem  [opwf_pkg::BIN_COUNT];

    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[wa_reg] <= {pix_in.intensity_bin, pix_in.in_blue,
                                 pix_in.in_green, pix_in.in_red};
        if (state_reg == ST_WALK)
            line_q_reg <= line_mem[a_reg];
        if (hist_we)
        begin
            cnt_mem[hist_wa] <= hist_wcnt;
            sum_mem[hist_wa] <= hist_wsum;
        end
        if (hist_re)
        begin
            cnt_q_reg <= cnt_mem[hist_ra];
            sum_q_reg <= sum_mem[hist_ra];
        end
    end

    // Control, pipeline and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            width_reg    <= opwf_pkg::RST_FRAME_WIDTH;
            height_reg   <= opwf_pkg::RST_FRAME_HEIGHT;
            radius_reg   <= opwf_pkg::RST_WINDOW_RADIUS;
            k_reg        <= '0;
            wa_reg       <= '0;
            xc_reg       <= '0;
            yc_reg       <= '0;
            pa_reg       <= '0;
            last_reg     <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            wr_vld_reg   <= 1'b0;
            sc_vld_reg   <= 1'b0;
            scan_idx_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            // Histogram pipeline: line data in stage two, bin update in stage three.
            s2_vld_reg <= (state_reg == ST_WALK);
            s3_vld_reg <= s2_vld_reg;
            s3_bin_reg <= line_q_reg[31:24];
            s3_rgb_reg <= {8'd0, line_q_reg[23:16], 8'd0, line_q_reg[15:8],
                           8'd0, line_q_reg[7:0]};
            wr_vld_reg <= s3_vld_reg;
            wr_bin_reg <= s3_bin_reg;
            wr_cnt_reg <= hist_wcnt;
            wr_sum_reg <= hist_wsum;
            sc_vld_reg <= 1'b0;

            // Drop the result once taken; the emit state reloads it itself.
            if (pix_out.ready && (state_reg != ST_EMIT))
                out_vld_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    scan_idx_reg <= scan_idx_reg + SCW'(1);
                    if (scan_idx_reg == SCW'(opwf_pkg::BIN_COUNT - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (k_reg < delay)
                        begin
                            k_reg <= k_reg + KW'(1);
                            if (k_reg < total)
                                wa_reg <= addr_add(wa_reg, AW'(1));
                        end
                        else if (p_idx >= total)
                        begin
                            // Stray tick past the frame: restart.
                            k_reg  <= '0;
                            wa_reg <= '0;
                            xc_reg <= '0;
                            yc_reg <= '0;
                            pa_reg <= '0;
                        end
                        else
                        begin
                            last_reg <= (p_idx == total - KW'(1));
                            if (p_idx == total - KW'(1))
                            begin
                                k_reg  <= '0;
                                wa_reg <= '0;
                            end
                            else
                            begin
                                k_reg <= k_reg + KW'(1);
                                if (k_reg < total)
                                    wa_reg <= addr_add(wa_reg, AW'(1));
                            end
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP:
                begin
                    rs_reg       <= win_start;
                    a_reg        <= win_start;
                    col_reg      <= '0;
                    row_reg      <= '0;
                    cols_m1_reg  <= cols_diff[3:0];
                    rows_m1_reg  <= rows_diff[3:0];
                    best_cnt_reg <= '0;
                    best_sum_reg <= '0;
                    state_reg    <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (col_reg == cols_m1_reg)
                    begin
                        if (row_reg == rows_m1_reg)
                            state_reg <= ST_DRAIN;
                        else
                        begin
                            rs_reg  <= addr_add(rs_reg, AW'(w_eff));
                            a_reg   <= addr_add(rs_reg, AW'(w_eff));
                            row_reg <= row_reg + 4'd1;
                            col_reg <= '0;
                        end
                    end
                    else
                    begin
                        a_reg   <= addr_add(a_reg, AW'(1));
                        col_reg <= col_reg + 4'd1;
                    end
                end
                ST_DRAIN:
                begin
                    scan_idx_reg <= '0;
                    if (!s2_vld_reg && !s3_vld_reg)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // Read each bin, keep the first maximum, write the bin back as zero.
                    if (!scan_idx_reg[BW])
                    begin
                        scan_idx_reg <= scan_idx_reg + SCW'(1);
                        sc_vld_reg   <= 1'b1;
                        sc_bin_reg   <= scan_idx_reg[BW-1:0];
                    end
                    if (sc_vld_reg && (cnt_q_reg > best_cnt_reg))
                    begin
                        best_cnt_reg <= cnt_q_reg;
                        best_sum_reg <= sum_q_reg;
                    end
                    if (scan_idx_reg[BW] && !sc_vld_reg)
                    begin
                        ch_reg    <= 2'd0;
                        bit_reg   <= 4'd15;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // One quotient bit per cycle, restoring.
                    rem_reg <= div_ge ? (CW+1)'(div_sh - (CW+2)'(best_cnt_reg))
                                      : div_sh[CW:0];
                    quo_reg <= {quo_reg[HW-2:0], div_ge};
                    bit_reg <= bit_reg - 4'd1;
                    if (bit_reg == 4'd0)
                        state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    unique case (ch_reg)
                        2'd0:    res_r_reg <= q_sat;
                        2'd1:    res_g_reg <= q_sat;
                        default: res_b_reg <= q_sat;
                    endcase
                    rem_reg <= '0;
                    quo_reg <= '0;
                    bit_reg <= 4'd15;
                    if (ch_reg == 2'd2)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_vld_reg || pix_out.ready)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_r_reg    <= res_r_reg;
                        out_g_reg    <= res_g_reg;
                        out_b_reg    <= res_b_reg;
                        out_done_reg <= last_reg;
                        // Advance the centre; drop back to the origin after the last pixel.
                        if (last_reg)
                        begin
                            xc_reg <= '0;
                            yc_reg <= '0;
                            pa_reg <= '0;
                        end
                        else
                        begin
                            pa_reg <= addr_add(pa_reg, AW'(1));
                            if (xc_reg == w_m1)
                            begin
                                xc_reg <= '0;
                                yc_reg <= yc_reg + YW'(1);
                            end
                            else
                                xc_reg <= xc_reg + XW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase

            // A register write restarts the frame.
            if (cfg.valid && cfg.ready
                && ((cfg.index == opwf_pkg::REG_FRAME_WIDTH)
                    || (cfg.index == opwf_pkg::REG_FRAME_HEIGHT)
                    || (cfg.index == opwf_pkg::REG_WINDOW_RADIUS)))
            begin
                if (cfg.index == opwf_pkg::REG_FRAME_WIDTH)
                    width_reg <= cfg.data[WW-1:0];
                if (cfg.index == opwf_pkg::REG_FRAME_HEIGHT)
                    height_reg <= cfg.data[HTW-1:0];
                if (cfg.index == opwf_pkg::REG_WINDOW_RADIUS)
                    radius_reg <= cfg.data[RW-1:0];
                k_reg  <= '0;
                wa_reg <= '0;
                xc_reg <= '0;
                yc_reg <= '0;
                pa_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire
